>>> sv/tmed_pkg.sv
package tmed_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        StMore = 2'd0,
        StDone = 2'd1,
        StErr  = 2'd2
    } t_status;

    localparam int OutLenW = 16;
    localparam int NameLen = 14;
    localparam int QDepth  = 4;
    localparam int QPtrW   = 2;
    localparam int QCntW   = 3;

    localparam logic [7:0] ChCr    = 8'h0d;
    localparam logic [7:0] ChLf    = 8'h0a;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChColon = 8'h3a;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5a;

    // One classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] lc;
        logic [3:0] digit;
        logic       is_term;
        logic       is_blank;
        logic       is_digit;
        logic       is_sep;
    } t_byte_class;

    // Lower-case "content-length"
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6f; // o
            4'd2:    ch = 8'h6e; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6e; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2d; // -
            4'd8:    ch = 8'h6c; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6e; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> sv/tmed_front.sv
module tmed_front
    import tmed_pkg::*;
(
    input  logic        i_valid,
    input  logic [7:0]  i_in_byte,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_push,
    output t_byte_class o_class
);

    logic [7:0] w_diff;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign w_diff  = i_in_byte - ChZero;

    always_comb begin
        o_class.raw      = i_in_byte;
        o_class.lc       = (i_in_byte >= ChUpA && i_in_byte <= ChUpZ) ?
                           (i_in_byte + 8'd32) : i_in_byte;
        o_class.digit    = w_diff[3:0];
        o_class.is_term  = (i_in_byte == ChCr) || (i_in_byte == ChLf);
        o_class.is_blank = (i_in_byte == ChSpace) || (i_in_byte == ChTab);
        o_class.is_digit = (i_in_byte >= ChZero) && (i_in_byte <= ChNine);
        o_class.is_sep   = (i_in_byte == ChColon) || (i_in_byte == ChSpace);
    end

endmodule

>>> sv/tmed_queue.sv
module tmed_queue
    import tmed_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_byte_class      i_data,
    input  logic             i_pop,
    output t_byte_class      o_data,
    output logic             o_empty,
    output logic             o_full,
    output logic [QCntW-1:0] o_count
);

    t_byte_class      r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/tmed_back.sv
module tmed_back
    import tmed_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_byte_class        i_class,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [OutLenW-1:0] o_message_length
);

    localparam logic [LENGTH_BITS-1:0] LenMax = '1;

    typedef enum logic [2:0] {
        PhText,
        PhTerm1,
        PhTerm,
        PhName,
        PhSep,
        PhNum,
        PhBody
    } t_phase;

    t_phase                   r_phase,   n_phase;
    logic [1:0]               r_term,    n_term;
    logic [7:0]               r_first,   n_first;
    logic [3:0]               r_idx,     n_idx;
    logic                     r_seen,    n_seen;
    logic [LENGTH_BITS-1:0]   r_blen,    n_blen;
    logic [LENGTH_BITS-1:0]   r_rem,     n_rem;
    logic [LENGTH_BITS-1:0]   r_bcount,  n_bcount;
    logic                     r_valid;
    t_status                  r_status,  n_status;
    logic [OutLenW-1:0]       r_len;
    logic [LENGTH_BITS-1:0]   w_len;
    logic [LENGTH_BITS+OutLenW-1:0] w_len_ext;
    logic [LENGTH_BITS+3:0]   w_times10;
    logic [3:0]               w_base;
    logic                     w_hit;
    logic                     w_do_name;
    logic                     w_do_text;

    assign o_pop            = !i_q_empty && (!r_valid || !i_stall);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_message_length = r_len;

    assign w_times10 = ({4'd0, r_blen} << 3) + ({4'd0, r_blen} << 1)
                       + (LENGTH_BITS+4)'(i_class.digit);
    assign w_base    = (r_phase == PhName) ? r_idx : 4'd0;
    assign w_hit     = (w_base < 4'(NameLen)) && (i_class.lc == name_char(w_base));
    assign w_len_ext = {{OutLenW{1'b0}}, w_len};

    always_comb begin
        n_phase   = r_phase;
        n_term    = r_term;
        n_first   = r_first;
        n_idx     = r_idx;
        n_seen    = r_seen;
        n_blen    = r_blen;
        n_rem     = r_rem;
        n_bcount  = r_bcount;
        n_status  = StMore;
        w_do_name = 1'b0;
        w_do_text = 1'b0;
        w_len     = LenMax;

        if (r_bcount == LenMax) begin
            n_status = StErr;
        end else begin
            n_bcount = r_bcount + 1'b1;
            w_len    = r_bcount + 1'b1;
            unique case (r_phase)
                PhTerm1: begin
                    if (i_class.is_term) begin
                        n_term = 2'd2;
                        if (i_class.raw == r_first) begin
                            if (r_blen == '0) begin
                                n_status = StDone;
                            end else begin
                                n_rem   = r_blen;
                                n_phase = PhBody;
                            end
                        end else begin
                            n_phase = PhTerm;
                        end
                    end else if (i_class.is_blank) begin
                        n_phase = PhTerm;
                    end else begin
                        n_term = 2'd0;
                        if (!r_seen) begin
                            n_idx     = 4'd0;
                            w_do_name = 1'b1;
                        end else begin
                            n_phase = PhText;
                        end
                    end
                end
                PhTerm: begin
                    if (i_class.is_term) begin
                        if (r_term < 2'd3) begin
                            n_term = r_term + 1'b1;
                        end
                        if (n_term == 2'd3) begin
                            if (r_blen == '0) begin
                                n_status = StDone;
                            end else begin
                                n_rem   = r_blen;
                                n_phase = PhBody;
                            end
                        end
                    end else if (i_class.is_blank && r_term < 2'd3) begin
                        // absorbed
                    end else begin
                        n_term = 2'd0;
                        if (!r_seen) begin
                            n_idx     = 4'd0;
                            w_do_name = 1'b1;
                        end else begin
                            n_phase = PhText;
                        end
                    end
                end
                PhName: begin
                    w_do_name = 1'b1;
                end
                PhSep: begin
                    if (i_class.is_sep) begin
                        // skipped
                    end else if (i_class.is_digit) begin
                        n_blen  = LENGTH_BITS'(i_class.digit);
                        n_phase = PhNum;
                    end else begin
                        n_status = StErr;
                    end
                end
                PhNum: begin
                    if (i_class.is_digit) begin
                        if (w_times10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
                            n_status = StErr;
                        end else begin
                            n_blen = w_times10[LENGTH_BITS-1:0];
                        end
                    end else begin
                        w_do_text = 1'b1;
                    end
                end
                PhBody: begin
                    if (r_rem != '0) begin
                        n_rem = r_rem - 1'b1;
                    end
                    if (n_rem == '0) begin
                        n_status = StDone;
                    end
                end
                default: begin
                    w_do_text = 1'b1;
                end
            endcase

            if (w_do_name) begin
                if (w_hit) begin
                    n_idx = w_base + 4'd1;
                    if (n_idx == 4'(NameLen)) begin
                        n_seen  = 1'b1;
                        n_phase = PhSep;
                    end else begin
                        n_phase = PhName;
                    end
                end else begin
                    n_idx     = w_base;
                    w_do_text = 1'b1;
                end
            end

            if (w_do_text) begin
                if (i_class.is_term) begin
                    n_term  = 2'd1;
                    n_first = i_class.raw;
                    n_phase = PhTerm1;
                end else begin
                    n_phase = PhText;
                end
            end
        end

        if (n_status != StMore) begin
            n_phase  = PhText;
            n_term   = '0;
            n_first  = '0;
            n_idx    = '0;
            n_seen   = 1'b0;
            n_blen   = '0;
            n_rem    = '0;
            n_bcount = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhText;
            r_term   <= '0;
            r_first  <= '0;
            r_idx    <= '0;
            r_seen   <= 1'b0;
            r_blen   <= '0;
            r_rem    <= '0;
            r_bcount <= '0;
            r_valid  <= 1'b0;
            r_status <= StMore;
        end else begin
            if (o_pop) begin
                r_phase  <= n_phase;
                r_term   <= n_term;
                r_first  <= n_first;
                r_idx    <= n_idx;
                r_seen   <= n_seen;
                r_blen   <= n_blen;
                r_rem    <= n_rem;
                r_bcount <= n_bcount;
                r_valid  <= 1'b1;
                r_status <= n_status;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_len <= w_len_ext[OutLenW-1:0];
        end
    end

endmodule

>>> sv/text_message_end_detector.sv
// Message end detector for RTSP/HTTP style text. One message byte enters per
// transfer on the input channel and exactly one result leaves per byte on the
// output channel: status 0 (need more bytes), 1 (message complete at this
// byte) or 2 (error), plus the running byte count of the message, including
// this byte (low 16 bits). A run of CR/LF ends a line; three terminators, or
// two identical ones back to back, end the header. The first line after the
// request line that starts with "Content-Length" (any case) supplies a decimal
// body length, which is counted out after the header. A malformed number, a
// body length or message size above 2^LENGTH_BITS-1 gives status 2. After any
// completion or error the parser starts a fresh message. Throughput is one
// byte per clock while the output does not stall; each byte is first queued,
// then the parser registers its result. The front end classifies bytes into
// a four-entry queue and the back end parser steps once per byte, so the
// input only stalls once the queue has filled behind a stalled output.
module text_message_end_detector
    import tmed_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_in_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [OutLenW-1:0] o_message_length
);

    t_byte_class      w_in_class;
    t_byte_class      w_q_class;
    logic             w_push;
    logic             w_pop;
    logic             w_q_empty;
    logic             w_q_full;
    logic [QCntW-1:0] w_q_count;

    // Front: accept and classify
    tmed_front u_front (
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_q_full  (w_q_full),
        .o_stall   (o_stall),
        .o_push    (w_push),
        .o_class   (w_in_class)
    );

    // Decoupling queue
    tmed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_class),
        .i_pop   (w_pop),
        .o_data  (w_q_class),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_count (w_q_count)
    );

    // Back: header/body parser with registered result
    tmed_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .i_class          (w_q_class),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_message_length (o_message_length)
    );

    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= QCntW'(QDepth))
        else $error("queue count exceeds depth");

    // parser only steps on a held byte
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("pop from empty queue");

    // every accepted byte lands in the queue next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_q_count == $past(w_q_count) + 1'b1))
        else $error("accepted byte lost");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == StMore || o_status == StDone || o_status == StErr))
        else $error("undefined status code");

endmodule
